### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

### rtl/eesp_pkg.sv
`timescale 1ns / 1ps
package eesp_pkg;
  localparam int LevelDepthDefault = 8;
  localparam logic [1:0] RK_HDR = 2'd0;
  localparam logic [1:0] RK_INT = 2'd1;
  localparam logic [1:0] RK_PASS = 2'd2;
  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_ID = 3'd1;
  localparam logic [2:0] ERR_LEN = 3'd2;
  localparam logic [2:0] ERR_INT = 3'd3;
  localparam logic [2:0] ERR_DEEP = 3'd4;
  localparam logic [2:0] EK_SKIP = 3'd0;
  localparam logic [2:0] EK_MASTER = 3'd1;
  localparam logic [2:0] EK_UINT = 3'd2;
  localparam logic [2:0] EK_SINT = 3'd3;
  localparam logic [2:0] EK_PASS = 3'd4;
  localparam logic [0:0] CFG_ID_MAX = 1'd0;
  localparam logic [0:0] CFG_LEN_MAX = 1'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] element_kind;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  error_code;
    logic [31:0] element_id;
    logic [55:0] element_length;
    logic        length_unknown;
    logic [3:0]  levels_closed;
    logic [3:0]  nesting_depth;
    logic [63:0] int_value;
    logic [7:0]  payload_byte;
    logic        last_byte;
  } out_t;

  // Position of the highest set bit from the top, 1..8; 9 for a zero byte.
  function automatic logic [3:0] marker_width(input logic [7:0] b);
    logic [3:0] w;
    w = 4'd9;
    for (int i = 7; i >= 0; i--) begin
      if (b[i] && w == 4'd9) w = 4'(8 - i);
    end
    return w;
  endfunction
endpackage

### rtl/eesp_stream_if.sv
`timescale 1ns / 1ps
interface eesp_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/ebml_element_stream_parser_top.sv
`timescale 1ns / 1ps
// EBML element stream parser.
// Channel in_ch carries one stream byte per word with the element kind, which
// is sampled on the last length byte. Channel out_ch carries header, integer
// and pass-through results; at most one result per input byte.
// The configuration port (cfg_we, cfg_index, cfg_data) sets the widest ID and
// length fields; write it only while the block is idle.
// A two-entry queue takes bytes in at one per cycle while it has room; the
// back end handles one byte per cycle while it is not walking the level
// stack and the receiver does not stall. On the first ID byte of each
// element the back end walks the level stack, each level check passing
// through a wait state for the registered stack memory read and a check
// state. A result shows on out_ch the cycle after its byte leaves the queue.
// When the receiver stalls, the output register holds and the back end
// waits; the queue still fills. Synchronous reset empties the queue, clears
// the level count and clears a halt caused by an error; until then an error
// makes the block drop every further byte without a result.
module ebml_element_stream_parser_top import eesp_pkg::*; #(
  parameter int LEVEL_DEPTH = LevelDepthDefault
) (
  input  logic         clk,
  input  logic         rst,
  eesp_stream_if.sink   in_ch,
  eesp_stream_if.source out_ch,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [3:0]   cfg_data
);
  logic [2:0]  id_max_bytes;
  logic [3:0]  length_max_bytes;
  logic        q_valid, q_pop;
  in_t         q_data;
  logic [63:0] q_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_max_bytes <= 3'd4;
      length_max_bytes <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ID_MAX: id_max_bytes <= cfg_data[2:0];
        CFG_LEN_MAX: length_max_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  eesp_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data(in_ch.payload), .q_valid(q_valid), .q_pop(q_pop),
    .q_data(q_data), .q_pos(q_pos)
  );

  eesp_back #(.LEVEL_DEPTH(LEVEL_DEPTH)) u_back (
    .clk(clk), .rst(rst), .id_max_bytes(id_max_bytes),
    .length_max_bytes(length_max_bytes), .q_valid(q_valid), .q_pop(q_pop),
    .q_data(q_data), .q_pos(q_pos), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_data(out_ch.payload)
  );
endmodule

### rtl/eesp_ram.sv
`timescale 1ns / 1ps
module eesp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/eesp_front.sv
`timescale 1ns / 1ps
// Front part: takes bytes, tags each with its stream offset and queues it.
module eesp_front import eesp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        q_valid,
  input  logic        q_pop,
  output in_t         q_data,
  output logic [63:0] q_pos
);
  in_t         buf_data [2];
  logic [63:0] buf_pos [2];
  logic [1:0]  cnt;
  logic        wp, rp;
  logic [63:0] offset;
  logic        push;

  assign in_ready = (cnt != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt != 2'd0);
  assign q_data = buf_data[rp];
  assign q_pos = buf_pos[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_data[wp] <= in_data;
      buf_pos[wp] <= offset;
    end
    if (rst) begin
      cnt <= 2'd0;
      wp <= 1'b0;
      rp <= 1'b0;
      offset <= 64'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
        offset <= offset + 64'd1;
      end
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end
endmodule

### rtl/eesp_back.sv
`timescale 1ns / 1ps
// Back part: header decode, level stack, payload handling and output register.
module eesp_back import eesp_pkg::*; #(
  parameter int LEVEL_DEPTH = LevelDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  id_max_bytes,
  input  logic [3:0]  length_max_bytes,
  input  logic        q_valid,
  output logic        q_pop,
  input  in_t         q_data,
  input  logic [63:0] q_pos,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data
);
  localparam int AW = $clog2(LEVEL_DEPTH);
  localparam int CW = $clog2(LEVEL_DEPTH + 1);
  localparam logic [1:0] PH_ID = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_PAY = 2'd2;
  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_POP = 2'd1;
  localparam logic [1:0] ST_CHK = 2'd2;

  logic [1:0]  phase, st;
  logic [3:0]  fexp, fseen;
  logic [31:0] id_acc;
  logic [55:0] len_acc;
  logic        ones;
  logic [2:0]  kind_l;
  logic [55:0] remain;
  logic [63:0] val;
  logic [CW-1:0] lcount;
  logic [CW-1:0] pend;
  logic        halted;
  logic [LEVEL_DEPTH-1:0] open_end;
  logic [63:0] top_end;
  logic [63:0] first_pos;
  logic [3:0]  first_w;

  logic        ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [63:0] ram_wd;

  eesp_ram #(.WIDTH(64), .DEPTH(LEVEL_DEPTH)) u_stack (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(top_end)
  );

  logic [7:0]  b;
  logic [2:0]  k;
  logic [3:0]  w, idlim, lenlim;
  logic        can_out, take;
  logic [3:0]  fseen_n;
  logic [55:0] len_n, rem_n;
  logic [63:0] val_n, endp, endsum;
  logic [7:0]  lmask;
  logic        ones_n, endov;
  logic [6:0]  bits;
  logic [63:0] sext;
  logic        len_err, len_done, emit;
  logic [2:0]  hdr_err;
  logic [3:0]  hdr_depth;

  assign b = q_data.data_byte;
  assign k = q_data.element_kind;
  assign w = marker_width(b);
  assign idlim = (id_max_bytes == 3'd0) ? 4'd1 :
                 (id_max_bytes > 3'd4) ? 4'd4 : {1'b0, id_max_bytes};
  assign lenlim = (length_max_bytes == 4'd0) ? 4'd1 :
                  (length_max_bytes > 4'd8) ? 4'd8 : length_max_bytes;
  assign can_out = !out_valid || out_ready;
  assign take = q_valid && !halted && st == ST_RUN && can_out;
  assign q_pop = take || (q_valid && halted);
  assign ram_ra = (lcount == '0) ? '0 : AW'(lcount - CW'(1));

  always_comb begin
    lmask = 8'h80 >> (w - 4'd1);
    fseen_n = fseen + 4'd1;
    if (fseen == 4'd0) begin
      len_n = {48'd0, b & (lmask - 8'd1)};
      ones_n = ((b & (lmask - 8'd1)) == (lmask - 8'd1));
    end else begin
      len_n = {len_acc[47:0], b};
      ones_n = ones && (b == 8'hff);
    end
    rem_n = (remain != 56'd0) ? remain - 56'd1 : remain;
    val_n = {val[55:0], b};
    bits = {len_acc[3:0], 3'b000};
    sext = val_n;
    if (kind_l == EK_SINT && bits != 7'd0 && bits < 7'd64 && val_n[bits[5:0] - 6'd1])
      sext = val_n | ({64{1'b1}} << bits[5:0]);
    endsum = q_pos + 64'd1 + {8'd0, len_n};
    endov = endsum < q_pos + 64'd1;
    endp = endov ? {64{1'b1}} : endsum;
    len_err = (fseen == 4'd0) && (w > lenlim);
    len_done = fseen_n >= ((fseen == 4'd0) ? w : fexp);
    hdr_err = ERR_NONE;
    hdr_depth = 4'(lcount);
    if (k == EK_MASTER) begin
      if (lcount >= CW'(LEVEL_DEPTH)) hdr_err = ERR_DEEP;
      else hdr_depth = 4'(lcount + CW'(1));
    end else if ((k == EK_UINT || k == EK_SINT) && (len_n < 56'd1 || len_n > 56'd8)) begin
      hdr_err = ERR_INT;
    end
    emit = take && ((phase == PH_ID && fseen == 4'd0 && w > idlim) ||
                    (phase == PH_LEN && (len_err || len_done)) ||
                    (phase != PH_ID && phase != PH_LEN &&
                     (kind_l == EK_PASS ||
                      ((kind_l == EK_UINT || kind_l == EK_SINT) && rem_n == 56'd0))));
  end

  always_ff @(posedge clk) begin
    ram_we <= take && phase == PH_LEN && !len_err && len_done && k == EK_MASTER &&
              lcount < CW'(LEVEL_DEPTH);
    ram_wa <= AW'(lcount);
    ram_wd <= endp;
    if (rst) begin
      phase <= PH_ID; st <= ST_RUN;
      fexp <= '0; fseen <= '0; id_acc <= '0; len_acc <= '0; ones <= 1'b0;
      kind_l <= '0; remain <= '0; val <= '0; lcount <= '0; pend <= '0;
      halted <= 1'b0; open_end <= '0; out_valid <= 1'b0;
      first_pos <= '0; first_w <= '0;
    end else begin
      out_valid <= emit || (out_valid && !out_ready);
      case (st)
        ST_POP: begin
          // Stack top read is registered; wait in this state for it.
          st <= ST_CHK;
        end
        ST_CHK: begin
          if (lcount != '0 && !open_end[AW'(lcount - CW'(1))] &&
              first_pos >= top_end) begin
            lcount <= lcount - CW'(1);
            pend <= pend + CW'(1);
            st <= ST_POP;
          end else begin
            st <= ST_RUN;
            if (first_w == 4'd1) begin
              phase <= PH_LEN; fexp <= '0; fseen <= '0;
            end else begin
              fexp <= first_w;
            end
          end
        end
        default: begin
          if (take) begin
            case (phase)
              PH_ID: begin
                if (fseen == 4'd0) begin
                  id_acc <= {24'd0, b};
                  if (w > idlim) begin
                    halted <= 1'b1;
                    out_data <= '{RK_HDR, ERR_ID, {24'd0, b}, 56'd0, 1'b0, 4'd0,
                                  4'(lcount), 64'd0, 8'd0, 1'b0};
                  end else begin
                    first_pos <= q_pos; first_w <= w;
                    pend <= '0; fseen <= 4'd1;
                    st <= ST_POP;
                  end
                end else begin
                  id_acc <= {id_acc[23:0], b};
                  if (fseen_n >= fexp) begin
                    phase <= PH_LEN; fseen <= '0; fexp <= '0;
                  end else begin
                    fseen <= fseen_n;
                  end
                end
              end
              PH_LEN: begin
                if (len_err) begin
                  halted <= 1'b1;
                  out_data <= '{RK_HDR, ERR_LEN, id_acc, 56'd0, 1'b0, 4'd0,
                                4'(lcount), 64'd0, 8'd0, 1'b0};
                end else begin
                  len_acc <= len_n; ones <= ones_n;
                  if (!len_done) begin
                    fseen <= fseen_n;
                    if (fseen == 4'd0) fexp <= w;
                  end else begin
                    fseen <= '0; fexp <= '0; kind_l <= k; pend <= '0;
                    out_data <= '{RK_HDR, hdr_err, id_acc, len_n, ones_n, 4'(pend),
                                  hdr_depth, 64'd0, 8'd0, 1'b0};
                    if (k == EK_MASTER) begin
                      phase <= PH_ID;
                      if (lcount >= CW'(LEVEL_DEPTH)) begin
                        halted <= 1'b1;
                      end else begin
                        open_end[AW'(lcount)] <= ones_n;
                        lcount <= lcount + CW'(1);
                      end
                    end else if (k == EK_UINT || k == EK_SINT) begin
                      if (len_n < 56'd1 || len_n > 56'd8) begin
                        halted <= 1'b1;
                        phase <= PH_ID;
                      end else begin
                        val <= '0; remain <= len_n; phase <= PH_PAY;
                      end
                    end else if (len_n != 56'd0) begin
                      remain <= len_n; phase <= PH_PAY;
                    end else begin
                      phase <= PH_ID;
                    end
                  end
                end
              end
              default: begin
                remain <= rem_n;
                if (kind_l == EK_UINT || kind_l == EK_SINT) begin
                  val <= val_n;
                  if (rem_n == 56'd0) begin
                    phase <= PH_ID;
                    out_data <= '{RK_INT, ERR_NONE, id_acc, len_acc, 1'b0, 4'd0,
                                  4'(lcount), sext, 8'd0, 1'b0};
                  end
                end else if (kind_l == EK_PASS) begin
                  if (rem_n == 56'd0) phase <= PH_ID;
                  out_data <= '{RK_PASS, ERR_NONE, id_acc, len_acc, ones, 4'd0,
                                4'(lcount), 64'd0, b, rem_n == 56'd0};
                end else if (rem_n == 56'd0) begin
                  phase <= PH_ID;
                end
              end
            endcase
          end
        end
      endcase
    end
  end
endmodule

### rtl/eesp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module eesp_checker import eesp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);
  `CHK_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `CHK_IMPL(a_err_hdr, clk, rst, out_valid && out_data.error_code != ERR_NONE, out_data.result_kind == RK_HDR)
  `CHK_IMPL(a_pass_fields, clk, rst, out_valid && out_data.result_kind != RK_PASS, !out_data.last_byte && out_data.payload_byte == 8'd0)
  `CHK_IMPL(a_int_closed, clk, rst, out_valid && out_data.result_kind != RK_HDR, out_data.levels_closed == 4'd0)
endmodule

bind ebml_element_stream_parser_top eesp_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.payload)
);
